// ===== hw/rtl/tmm_pkg.sv =====
// Shared types and constants for the trimmed-mean motion block.
`timescale 1ns / 1ps

package tmm_pkg;

   localparam int COMPONENT_BITS = 16;
   localparam int KEPT_BITS      = 9;
   localparam int TRIM_DIV       = 5;

   typedef struct packed {
      logic signed [COMPONENT_BITS-1:0] motion_x;
      logic signed [COMPONENT_BITS-1:0] motion_y;
      logic                             last_item;
   } req_word_type;

   typedef struct packed {
      logic signed [COMPONENT_BITS-1:0] mean_x;
      logic signed [COMPONENT_BITS-1:0] mean_y;
      logic        [KEPT_BITS-1:0]      kept_count;
      logic                             overflow;
   } rsp_word_type;

   typedef struct packed {
      logic load;      // store an accepted word and count it
      logic rd_i;      // read the outer entry
      logic lat_i;     // latch the outer entry, clear ranks and inner index
      logic scan;      // read the inner entry and advance
      logic acc;       // add the outer entry if its rank is kept
      logic div_init;  // load divider operands
      logic div_step;  // one restoring division step
      logic out_en;    // present the result and close the set
   } cmd_type;

   typedef struct packed {
      logic last_load;
      logic j_last;
      logic i_last;
      logic div_last;
   } stat_type;

endpackage

// ===== hw/rtl/tmm_ctrl.sv =====
// Controller state machine for the trimmed-mean motion block.
`timescale 1ns / 1ps

module tmm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tmm_pkg::stat_type stat,
   output tmm_pkg::cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RDI  = 4'd1;
   localparam logic [3:0] ST_LATI = 4'd2;
   localparam logic [3:0] ST_SCAN = 4'd3;
   localparam logic [3:0] ST_TAIL = 4'd4;
   localparam logic [3:0] ST_ACC  = 4'd5;
   localparam logic [3:0] ST_DIVI = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start && stat.last_load) begin
               state_in = ST_RDI;
            end
         end
         ST_RDI: begin
            cmd.rd_i = 1'b1;
            state_in = ST_LATI;
         end
         ST_LATI: begin
            cmd.lat_i = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.j_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.i_last ? ST_DIVI : ST_RDI;
         end
         ST_DIVI: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            cmd.out_en = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/tmm_datapath.sv =====
// Storage, rank counting, trimmed sums and dividers of the trimmed-mean block.
`timescale 1ns / 1ps

module tmm_datapath #(
   parameter int MAX_ITEMS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tmm_pkg::cmd_type      cmd,
   output tmm_pkg::stat_type     stat,
   input  tmm_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output tmm_pkg::rsp_word_type rsp_word
);

   localparam int CW   = tmm_pkg::COMPONENT_BITS;
   localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNTW = $clog2(MAX_ITEMS + 1);
   localparam int SUMW = CW + CNTW;
   localparam int DCW  = $clog2(SUMW);

   logic signed [CW-1:0] x_mem [MAX_ITEMS];
   logic signed [CW-1:0] y_mem [MAX_ITEMS];

   logic [CNTW-1:0] cnt_ff, cut_ff;
   logic [2:0]      mod5_ff;
   logic            ovf_ff;
   logic [AW-1:0]   i_ff, j_ff, idx_ff;
   logic            scan_ff;
   logic signed [CW-1:0] rd_x_ff, rd_y_ff, vi_x_ff, vi_y_ff;
   logic [CNTW-1:0] rank_x_ff, rank_y_ff;
   logic signed [SUMW-1:0] sum_x_ff, sum_y_ff;
   logic [SUMW-1:0] qx_ff, qy_ff;
   logic [CNTW:0]   rx_ff, ry_ff;
   logic            negx_ff, negy_ff;
   logic [DCW-1:0]  dcnt_ff;
   logic            rsp_strobe_ff;
   tmm_pkg::rsp_word_type rsp_word_ff;

   logic            full;
   logic [AW-1:0]   rd_addr;
   logic [CNTW-1:0] kept, hi_lim;
   logic            keep_x, keep_y;
   logic [CNTW:0]   tx, ty;
   logic            gx, gy;
   logic [SUMW-1:0] mx, my;

   assign full    = (cnt_ff == CNTW'(MAX_ITEMS));
   assign rd_addr = cmd.rd_i ? i_ff : j_ff;
   assign kept    = cnt_ff - (cut_ff << 1);
   assign hi_lim  = cnt_ff - cut_ff;
   assign keep_x  = (rank_x_ff >= cut_ff) && (rank_x_ff < hi_lim);
   assign keep_y  = (rank_y_ff >= cut_ff) && (rank_y_ff < hi_lim);

   assign stat.last_load = req_word.last_item;
   assign stat.j_last    = (CNTW'(j_ff) == cnt_ff - CNTW'(1));
   assign stat.i_last    = (CNTW'(i_ff) == cnt_ff - CNTW'(1));
   assign stat.div_last  = (dcnt_ff == DCW'(SUMW - 1));

   // Restoring division step on magnitudes; remainder stays below the divisor.
   assign tx = {rx_ff[CNTW-1:0], qx_ff[SUMW-1]};
   assign ty = {ry_ff[CNTW-1:0], qy_ff[SUMW-1]};
   assign gx = (tx >= {1'b0, kept});
   assign gy = (ty >= {1'b0, kept});
   assign mx = negx_ff ? (~qx_ff + SUMW'(1)) : qx_ff;
   assign my = negy_ff ? (~qy_ff + SUMW'(1)) : qy_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         x_mem[cnt_ff[AW-1:0]] <= req_word.motion_x;
         y_mem[cnt_ff[AW-1:0]] <= req_word.motion_y;
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         cut_ff        <= '0;
         mod5_ff       <= '0;
         ovf_ff        <= 1'b0;
         scan_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.out_en;
         scan_ff       <= cmd.scan;
         if (cmd.out_en) begin
            cnt_ff  <= '0;
            cut_ff  <= '0;
            mod5_ff <= '0;
            ovf_ff  <= 1'b0;
         end else if (cmd.load) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + CNTW'(1);
               // The trim count is the stored count divided by five, kept as we go.
               if (mod5_ff == 3'(tmm_pkg::TRIM_DIV - 1)) begin
                  mod5_ff <= '0;
                  cut_ff  <= cut_ff + CNTW'(1);
               end else begin
                  mod5_ff <= mod5_ff + 3'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= j_ff;
      if (cmd.load) begin
         i_ff     <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end
      if (cmd.lat_i) begin
         vi_x_ff   <= rd_x_ff;
         vi_y_ff   <= rd_y_ff;
         rank_x_ff <= '0;
         rank_y_ff <= '0;
         j_ff      <= '0;
      end
      if (cmd.scan) begin
         j_ff <= j_ff + AW'(1);
      end
      // Rank is the count of smaller entries, ties broken by position.
      if (scan_ff) begin
         if ((rd_x_ff < vi_x_ff) || ((rd_x_ff == vi_x_ff) && (idx_ff < i_ff))) begin
            rank_x_ff <= rank_x_ff + CNTW'(1);
         end
         if ((rd_y_ff < vi_y_ff) || ((rd_y_ff == vi_y_ff) && (idx_ff < i_ff))) begin
            rank_y_ff <= rank_y_ff + CNTW'(1);
         end
      end
      if (cmd.acc) begin
         i_ff <= i_ff + AW'(1);
         if (keep_x) begin
            sum_x_ff <= sum_x_ff + SUMW'(vi_x_ff);
         end
         if (keep_y) begin
            sum_y_ff <= sum_y_ff + SUMW'(vi_y_ff);
         end
      end
      if (cmd.div_init) begin
         negx_ff <= sum_x_ff[SUMW-1];
         negy_ff <= sum_y_ff[SUMW-1];
         qx_ff   <= sum_x_ff[SUMW-1] ? (~sum_x_ff + SUMW'(1)) : sum_x_ff;
         qy_ff   <= sum_y_ff[SUMW-1] ? (~sum_y_ff + SUMW'(1)) : sum_y_ff;
         rx_ff   <= '0;
         ry_ff   <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DCW'(1);
         rx_ff   <= gx ? (tx - {1'b0, kept}) : tx;
         ry_ff   <= gy ? (ty - {1'b0, kept}) : ty;
         qx_ff   <= {qx_ff[SUMW-2:0], gx};
         qy_ff   <= {qy_ff[SUMW-2:0], gy};
      end
      if (cmd.out_en) begin
         rsp_word_ff.mean_x     <= CW'(mx);
         rsp_word_ff.mean_y     <= CW'(my);
         rsp_word_ff.kept_count <= tmm_pkg::KEPT_BITS'(kept);
         rsp_word_ff.overflow   <= ovf_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== hw/rtl/trimmed_mean_motion_xy.sv =====
// Top level of the trimmed-mean motion estimator.
`timescale 1ns / 1ps

// Vectors are taken one per cycle while busy is low. The word with last_item
// set closes the set; busy then rises while the block ranks every stored
// entry against every other through one read port per axis store, followed
// by bit-serial division. The result is shown on rsp_word for one cycle with
// rsp_strobe high and cannot be held off. Vectors beyond MAX_ITEMS are
// dropped and reported in the overflow bit.
module trimmed_mean_motion_xy #(
   parameter int MAX_ITEMS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tmm_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output tmm_pkg::rsp_word_type rsp_word
);

   tmm_pkg::cmd_type  cmd;
   tmm_pkg::stat_type stat;

   tmm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   tmm_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule
